// ===== src/wsa_pkg.sv =====
// ----------------------------------------------------------------------------
// wsa_pkg
// Shared types and constants for the windowed sample average core.
// ----------------------------------------------------------------------------
`default_nettype none

package wsa_pkg;

	localparam int WINDOW_DEF   = 30;
	localparam int CHANNELS_DEF = 5;

	localparam int CHANNEL_W = 3;
	localparam int SAMPLE_W  = 24;
	localparam int FILL_W    = 5;
	localparam int STEP_W    = $clog2(SAMPLE_W + 1);

	typedef struct packed {
		logic [CHANNEL_W-1:0] channel;
		logic [SAMPLE_W-1:0]  sample;
	} sample_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] average;
		logic [FILL_W-1:0]   fill_count;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_UPDATE,
		ST_DIVIDE,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

// ===== src/wsa_ram.sv =====
// ----------------------------------------------------------------------------
// wsa_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module wsa_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== src/windowed_sample_average_core.sv =====
// ----------------------------------------------------------------------------
// windowed_sample_average_core
// Per-channel moving average over a ring of the last WINDOW samples, with a
// running sum and a bit-serial restoring divider.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  sample    in         sample_valid/sample_stall sample_data (channel, sample)
//  result    out        result_valid/result_stall result_data (average, fill_count)
//
//  One transaction at a time: accept, ring read, sum update, 24 divider steps
//  (one quotient bit per cycle), then delivery. An out-of-range channel skips
//  the ring read, sum update and divider and goes straight to delivery.
//  Reset clears the per-channel counts, positions and sums; the ring RAM is
//  not cleared and needs no clearing pass.
//  The result register decouples the sides: a new sample is taken while a
//  result still waits under result_stall.
// ----------------------------------------------------------------------------
`default_nettype none

module windowed_sample_average_core
	import wsa_pkg::*;
#(
	parameter int WINDOW   = WINDOW_DEF,
	parameter int CHANNELS = CHANNELS_DEF
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    sample_valid,
	output logic         sample_stall,
	input  wire sample_t sample_data,
	output logic         result_valid,
	input  wire logic    result_stall,
	output result_t      result_data
);

	localparam int POS_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int CNT_W   = $clog2(WINDOW + 1);
	localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int SUM_W   = SAMPLE_W + CNT_W;
	localparam int ADDR_W  = CH_W + POS_W;
	localparam int DEPTH   = CHANNELS << POS_W;

	state_t state_q, state_nxt;

	logic [POS_W-1:0] oldest_q [CHANNELS];
	logic [CNT_W-1:0] count_q  [CHANNELS];
	logic [SUM_W-1:0] sum_q    [CHANNELS];

	logic [CH_W-1:0]     ch_q;
	logic [SAMPLE_W-1:0] smp_q;
	logic [SUM_W-1:0]    psum_q;
	logic                full_q;
	logic [CNT_W-1:0]    div_q;
	logic [CNT_W-1:0]    rem_q;
	logic [SAMPLE_W-1:0] quo_q;
	logic [STEP_W-1:0]   step_q;
	logic                res_valid_q;
	result_t             res_q;

	logic                accept;
	logic                in_range;
	logic                ram_we;
	logic                ram_re;
	logic                res_load;
	logic [ADDR_W-1:0]   ram_waddr;
	logic [ADDR_W-1:0]   ram_raddr;
	logic [SAMPLE_W-1:0] ram_rdata;
	logic [CNT_W-1:0]    cur_cnt;
	logic [POS_W-1:0]    cur_old;
	logic [SUM_W-1:0]    old_ext;
	logic [SUM_W-1:0]    new_sum;
	logic [CNT_W:0]      trial;
	logic [CNT_W:0]      diff;
	logic                ge;
	logic [CNT_W+FILL_W-1:0] fill_ext;

	assign accept   = sample_valid && !sample_stall;
	assign in_range = 32'(sample_data.channel) < CHANNELS;
	assign cur_cnt  = count_q[ch_q];
	assign cur_old  = oldest_q[ch_q];
	assign old_ext  = full_q ? {{CNT_W{1'b0}}, ram_rdata} : '0;
	assign new_sum  = psum_q - old_ext;
	assign trial    = {rem_q, quo_q[SAMPLE_W-1]};
	assign diff     = trial - {1'b0, div_q};
	assign ge       = trial >= {1'b0, div_q};
	assign fill_ext = {{FILL_W{1'b0}}, div_q};

	assign ram_raddr = {ch_q, cur_old};
	assign ram_waddr = {ch_q, full_q ? cur_old : cur_cnt[POS_W-1:0]};

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_nxt = in_range ? ST_READ : ST_DONE;
				end
			end
			ST_READ:   state_nxt = ST_UPDATE;
			ST_UPDATE: state_nxt = ST_DIVIDE;
			ST_DIVIDE: begin
				if (step_q == STEP_W'(1)) begin
					state_nxt = ST_DONE;
				end
			end
			ST_DONE: begin
				if (res_load) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		sample_stall = (state_q != ST_IDLE);
		ram_re       = (state_q == ST_READ);
		ram_we       = (state_q == ST_UPDATE);
		res_load     = (state_q == ST_DONE) && (!res_valid_q || !result_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
			for (int i = 0; i < CHANNELS; i++) begin
				oldest_q[i] <= '0;
				count_q[i]  <= '0;
				sum_q[i]    <= '0;
			end
		end else begin
			state_q <= state_nxt;
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
			if (state_q == ST_UPDATE) begin
				sum_q[ch_q] <= new_sum;
				if (full_q) begin
					oldest_q[ch_q] <= (cur_old == POS_W'(WINDOW - 1)) ? '0 : cur_old + 1'b1;
				end else begin
					count_q[ch_q] <= cur_cnt + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				ch_q   <= CH_W'(sample_data.channel);
				smp_q  <= sample_data.sample;
				quo_q  <= '0;
				div_q  <= '0;
			end
			ST_READ: begin
				psum_q <= sum_q[ch_q] + {{CNT_W{1'b0}}, smp_q};
				full_q <= (cur_cnt == CNT_W'(WINDOW));
			end
			ST_UPDATE: begin
				div_q  <= full_q ? cur_cnt : cur_cnt + 1'b1;
				rem_q  <= new_sum[SUM_W-1:SAMPLE_W];
				quo_q  <= new_sum[SAMPLE_W-1:0];
				step_q <= STEP_W'(SAMPLE_W);
			end
			ST_DIVIDE: begin
				rem_q  <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
				quo_q  <= {quo_q[SAMPLE_W-2:0], ge};
				step_q <= step_q - 1'b1;
			end
			ST_DONE: begin
				if (res_load) begin
					res_q.average    <= quo_q;
					res_q.fill_count <= fill_ext[FILL_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	wsa_ram #(
		.WIDTH(SAMPLE_W),
		.DEPTH(DEPTH)
	) u_ring (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(smp_q),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign result_valid = res_valid_q;
	assign result_data  = res_q;

endmodule

`default_nettype wire

// ===== src/wsa_checker.sv =====
// ----------------------------------------------------------------------------
// wsa_checker
// Port-level checks for the windowed sample average core, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module wsa_checker
	import wsa_pkg::*;
(
	input wire logic    clk,
	input wire logic    arst_n,
	input wire logic    sample_valid,
	input wire logic    sample_stall,
	input wire sample_t sample_data,
	input wire logic    result_valid,
	input wire logic    result_stall,
	input wire result_t result_data
);

	// one transaction in flight: an accepted sample blocks the next one
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && !sample_stall |=> sample_stall)
		else $error("sample taken while previous transaction in flight");

	// a zero fill count only marks a rejected channel, which carries a zero average
	a_error_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result_data.fill_count == '0) |-> (result_data.average == '0))
		else $error("error result with nonzero average");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result_data))
		else $error("stalled result changed or dropped");

	a_sample_hold: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && sample_stall |=> sample_valid && $stable(sample_data))
		else $error("stalled sample changed or dropped");

endmodule

bind windowed_sample_average_core wsa_checker u_wsa_checker (.*);

`default_nettype wire

// ===== tb/windowed_sample_average_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// windowed_sample_average_checker
// Watches both channels of the windowed sample average core. Every accepted
// sample to a present channel updates a private per-channel ring, fill count,
// oldest position and running sum. Every accepted sample queues its expected
// result; every accepted result is compared field by field with the oldest one.
// ----------------------------------------------------------------------------
module windowed_sample_average_checker
	import wsa_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    sample_valid,
	input  wire logic    sample_stall,
	input  wire sample_t sample_data,
	input  wire logic    result_valid,
	input  wire logic    result_stall,
	input  wire result_t result_data,
	output int           fail_count,
	output int           pending,
	output int           checked_count,
	output int           overwrite_count,
	output int           reject_count
);

	localparam int SUM_W = SAMPLE_W + $clog2(WINDOW_DEF);

	logic [SAMPLE_W-1:0] ring [CHANNELS_DEF][WINDOW_DEF];
	logic [FILL_W-1:0]   oldest [CHANNELS_DEF];
	logic [FILL_W-1:0]   fill [CHANNELS_DEF];
	logic [SUM_W-1:0]    running_sum [CHANNELS_DEF];
	result_t             pending_averages [$];

	function automatic result_t absorb_sample(input sample_t s);
		result_t          r;
		int               c;
		int               pos;
		logic [SUM_W-1:0] quotient;
		r = '0;
		if (s.channel >= CHANNELS_DEF) begin
			reject_count++;
			return r;
		end
		c = int'(s.channel);
		if (fill[c] < WINDOW_DEF) begin
			pos = (oldest[c] + fill[c]) % WINDOW_DEF;
			fill[c] = fill[c] + 1'b1;
		end else begin
			pos = int'(oldest[c]);
			running_sum[c] = running_sum[c] - ring[c][pos];
			oldest[c] = FILL_W'((pos + 1) % WINDOW_DEF);
			overwrite_count++;
		end
		ring[c][pos] = s.sample;
		running_sum[c] = running_sum[c] + s.sample;
		quotient = running_sum[c] / fill[c];
		r.average = quotient[SAMPLE_W-1:0];
		r.fill_count = fill[c];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS_DEF; c++) begin
				oldest[c] = '0;
				fill[c] = '0;
				running_sum[c] = '0;
			end
			pending_averages.delete();
			pending = 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (pending_averages.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected transaction, average=%h fill_count=%0d",
						$time, result_data.average, result_data.fill_count);
				end else begin
					want = pending_averages.pop_front();
					checked_count++;
					if (result_data.average !== want.average) begin
						fail_count++;
						$display("%0t: average mismatch, expected %h, got %h",
							$time, want.average, result_data.average);
					end
					if (result_data.fill_count !== want.fill_count) begin
						fail_count++;
						$display("%0t: fill_count mismatch, expected %0d, got %0d",
							$time, want.fill_count, result_data.fill_count);
					end
				end
			end
			if (sample_valid && !sample_stall)
				pending_averages.push_back(absorb_sample(sample_data));
			pending = pending_averages.size();
		end
	end

endmodule

// ===== tb/windowed_sample_average_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// windowed_sample_average_core_tb
// Drives samples into the windowed sample average core with random gaps and
// random result back-pressure, including one long hold-off that fills the
// core. Directed samples hit the field extremes and absent channels, then
// random runs per channel wrap the rings with random, extreme and constant
// data. The checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module windowed_sample_average_core_tb;
	import wsa_pkg::*;

	localparam int ITEMS      = 1250;
	localparam int DIRECTED   = 16;
	localparam int IDLE_LIMIT = 3000;
	localparam int LONG_HOLD  = 400;
	localparam int DRAIN      = 40;
	localparam int CH_TOP     = (1 << CHANNEL_W) - 1;
	localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;

	typedef enum int {
		MODE_ANY,
		MODE_MAX,
		MODE_ZERO,
		MODE_SMALL,
		MODE_EXTREME
	} data_mode_t;

	logic    clk          = 1'b0;
	logic    arst_n       = 1'b0;
	logic    sample_valid = 1'b0;
	logic    sample_stall;
	sample_t sample_data  = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result_data;

	int fail_count;
	int pending;
	int checked_count;
	int overwrite_count;
	int reject_count;
	int samples_sent = 0;
	bit steady       = 1'b0;

	initial begin
		forever #6 clk = ~clk;
	end

	windowed_sample_average_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample_data  (sample_data),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_data  (result_data)
	);

	windowed_sample_average_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.sample_valid    (sample_valid),
		.sample_stall    (sample_stall),
		.sample_data     (sample_data),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.result_data     (result_data),
		.fail_count      (fail_count),
		.pending         (pending),
		.checked_count   (checked_count),
		.overwrite_count (overwrite_count),
		.reject_count    (reject_count)
	);

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [CHANNEL_W-1:0] pick_channel();
		if ($urandom_range(0, 11) == 0)
			return CHANNEL_W'($urandom_range(CHANNELS_DEF, CH_TOP));
		return CHANNEL_W'($urandom_range(0, CHANNELS_DEF - 1));
	endfunction

	function automatic logic [SAMPLE_W-1:0] pick_sample(input data_mode_t mode);
		case (mode)
			MODE_MAX:     return SAMPLE_MAX;
			MODE_ZERO:    return '0;
			MODE_SMALL:   return SAMPLE_W'($urandom_range(0, 255));
			MODE_EXTREME: return $urandom_range(0, 1) ? SAMPLE_MAX : '0;
			default:      return SAMPLE_W'($urandom());
		endcase
	endfunction

	task automatic send_sample(input logic [CHANNEL_W-1:0] ch, input logic [SAMPLE_W-1:0] smp);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_data <= '{channel: ch, sample: smp};
		sample_valid <= 1'b1;
		@(posedge clk);
		while (sample_stall)
			@(posedge clk);
		samples_sent++;
	endtask

	initial begin : result_pacing
		int  len;
		int  r;
		bit  held_long;
		held_long = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			r = $urandom_range(0, 99);
			if (!held_long && samples_sent >= 60) begin
				held_long = 1'b1;
				len = LONG_HOLD;
				result_stall <= 1'b1;
			end else if (r < 8) begin
				len = $urandom_range(100, 200);
				result_stall <= 1'b0;
			end else if (r < 50) begin
				len = $urandom_range(1, 30);
				result_stall <= 1'b0;
			end else if (r < 88) begin
				len = $urandom_range(1, 3);
				result_stall <= 1'b1;
			end else if (r < 97) begin
				len = $urandom_range(4, 12);
				result_stall <= 1'b1;
			end else begin
				len = $urandom_range(20, 80);
				result_stall <= 1'b1;
			end
			repeat (len) @(posedge clk);
		end
	end

	initial begin : watchdog
		int idle;
		idle = 0;
		wait (arst_n === 1'b1);
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((sample_valid && !sample_stall) || (result_valid && !result_stall))
				idle = 0;
			else
				idle++;
		end
		$display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
		$display("*** FAILED ***");
		$finish;
	end

	initial begin : stimulus
		int                   seg_len;
		int                   kind;
		data_mode_t           mode;
		logic [CHANNEL_W-1:0] ch;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_sample(3'd0, 24'h000000);
		send_sample(3'd0, 24'hFFFFFF);
		send_sample(3'd1, 24'hFFFFFF);
		send_sample(3'd1, 24'hFFFFFF);
		send_sample(3'd2, 24'h000001);
		send_sample(3'd2, 24'h000002);
		send_sample(3'd3, 24'hAAAAAA);
		send_sample(3'd3, 24'h555555);
		send_sample(3'd4, 24'h555555);
		send_sample(3'd4, 24'hAAAAAA);
		send_sample(3'd5, 24'h123456);
		send_sample(3'd6, 24'hFFFFFF);
		send_sample(3'd7, 24'h000000);
		send_sample(3'd7, 24'hAAAAAA);
		send_sample(3'd0, 24'h000100);
		send_sample(3'd4, 24'hFFFFFF);

		while (samples_sent < DIRECTED + ITEMS) begin
			kind = $urandom_range(0, 9);
			steady = ($urandom_range(0, 4) == 0);
			case ($urandom_range(0, 9))
				5:       mode = MODE_MAX;
				6:       mode = MODE_ZERO;
				7:       mode = MODE_SMALL;
				8, 9:    mode = MODE_EXTREME;
				default: mode = MODE_ANY;
			endcase
			seg_len = ($urandom_range(0, 7) == 0) ? $urandom_range(31, 70)
				: $urandom_range(1, 30);
			ch = pick_channel();
			repeat (seg_len) begin
				if (kind < 3)
					ch = pick_channel();
				send_sample(ch, pick_sample(mode));
			end
		end
		sample_valid <= 1'b0;

		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);

		$display("Summary: %0d samples sent, %0d results checked, %0d to absent channels,",
			samples_sent, checked_count, reject_count);
		$display("Summary: %0d samples replaced the oldest entry of a full window.",
			overwrite_count);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/wsa_pkg.sv
src/wsa_ram.sv
src/windowed_sample_average_core.sv
src/wsa_checker.sv
tb/windowed_sample_average_checker.sv
tb/windowed_sample_average_core_tb.sv
